// ===== sv/jcrf_pkg.sv =====
// jcrf_pkg: shared types and constants of the J1939 receive filter.
// Used by every module of the block; depends on nothing.
package jcrf_pkg;

   // Configuration register indexes
   localparam int unsigned CsrIdxW = 2;
   localparam logic [CsrIdxW-1:0] CSR_TARGET_PGN     = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_STAMP_INTERVAL = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_COMM_TIMEOUT   = 2'd2;
   localparam int unsigned CsrDataW = 16;

   // Configuration reset values
   localparam logic [15:0] TARGET_PGN_RST     = 16'd65340;
   localparam logic [7:0]  STAMP_INTERVAL_RST = 8'd100;
   localparam logic [15:0] COMM_TIMEOUT_RST   = 16'd1000;

   // Segments held by the local reassembly buffer
   localparam logic [7:0] MAX_SEGMENTS = 8'd11;

   // Listed source addresses
   localparam logic [7:0] SA_0 = 8'd71;
   localparam logic [7:0] SA_1 = 8'd23;
   localparam logic [7:0] SA_2 = 8'd29;
   localparam logic [7:0] SA_3 = 8'd228;
   localparam logic [7:0] SA_4 = 8'd221;
   localparam logic [7:0] SA_5 = 8'h4a;
   localparam logic [7:0] SA_6 = 8'hf4;

   // PDU format and specific codes
   localparam logic [7:0] PF_PROP_B  = 8'd255;
   localparam logic [7:0] PF_BCAST   = 8'd254;
   localparam logic [7:0] PF_PROP_A  = 8'd239;
   localparam logic [7:0] PF_TP_DT   = 8'd235;
   localparam logic [7:0] PF_TP_CM   = 8'd236;
   localparam logic [7:0] PS_MONITOR = 8'd251;
   localparam logic [7:0] PS_BUZZ_1  = 8'd153;
   localparam logic [7:0] PS_BUZZ_2  = 8'd170;
   localparam logic [7:0] PS_GLOBAL  = 8'd255;
   localparam logic [7:0] PS_TP_DEST = 8'h28;
   localparam logic [7:0] TP_CTRL_BAM = 8'd32;

   // Mirrored identifiers and selector codes
   localparam logic [28:0] ID_RELAY = 29'h18fff7dd;
   localparam logic [28:0] ID_HYD   = 29'h18ffede4;
   localparam logic [28:0] ID_AUTO  = 29'h18ffec47;
   localparam logic [28:0] ID_LAMP  = 29'h18ff9447;

   typedef enum logic [2:0] {
      MIRROR_NONE  = 3'd0,
      MIRROR_RELAY = 3'd1,
      MIRROR_HYD   = 3'd2,
      MIRROR_AUTO  = 3'd3,
      MIRROR_LAMP  = 3'd4
   } mirror_type;

   localparam logic OP_FRAME = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   typedef struct packed {
      logic        op;
      logic [28:0] ext_id;
      logic [31:0] data_low;
      logic [31:0] data_high;
   } item_type;

   typedef struct packed {
      logic [15:0] target_pgn;
      logic [7:0]  stamp_interval;
      logic [15:0] comm_timeout;
   } cfg_type;

   typedef struct packed {
      logic        accepted;
      logic        forward;
      mirror_type  mirror_sel;
      logic        stamp_due;
      logic        monitor_reset;
      logic        buzzer_update;
      logic        buzzer_active;
      logic        seg_write;
      logic [6:0]  seg_offset;
      logic [55:0] seg_data;
      logic        message_done;
      logic        comm_lost;
   } result_type;

   function automatic mirror_type mirror_of(input logic [28:0] id);
      mirror_type m;
      unique case (id)
         ID_RELAY: m = MIRROR_RELAY;
         ID_HYD:   m = MIRROR_HYD;
         ID_AUTO:  m = MIRROR_AUTO;
         ID_LAMP:  m = MIRROR_LAMP;
         default:  m = MIRROR_NONE;
      endcase
      return m;
   endfunction

   function automatic logic source_listed(input logic [7:0] sa);
      return (sa == SA_0) || (sa == SA_1) || (sa == SA_2) || (sa == SA_3) ||
             (sa == SA_4) || (sa == SA_5) || (sa == SA_6);
   endfunction

endpackage

// ===== sv/jcrf_csr.sv =====
// jcrf_csr: configuration registers written through the csr port.
// Depends on jcrf_pkg.
module jcrf_csr
   import jcrf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata,
   output cfg_type             cfg
);

   cfg_type cfg_ff, cfg_in;

   // Decode the register index and load the addressed field
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_TARGET_PGN:     cfg_in.target_pgn     = csr_wdata;
            CSR_STAMP_INTERVAL: cfg_in.stamp_interval = csr_wdata[7:0];
            CSR_COMM_TIMEOUT:   cfg_in.comm_timeout   = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_pgn     <= TARGET_PGN_RST;
         cfg_ff.stamp_interval <= STAMP_INTERVAL_RST;
         cfg_ff.comm_timeout   <= COMM_TIMEOUT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/jcrf_in_stage.sv =====
// jcrf_in_stage: input register of the request channel.
// Depends on jcrf_pkg.
module jcrf_in_stage
   import jcrf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  item_type req_item,
   output logic     stage_valid,
   input  logic     stage_take,
   output item_type stage_item
);

   logic     valid_ff, valid_in;
   item_type item_ff;

   // Accept when empty or when the held item moves on this cycle
   assign req_ready = !valid_ff || stage_take;

   always_comb begin
      valid_in = valid_ff;
      if (req_ready) valid_in = req_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the payload until the next transfer
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) item_ff <= req_item;
   end

   assign stage_valid = valid_ff;
   assign stage_item  = item_ff;

endmodule

// ===== sv/jcrf_engine.sv =====
// jcrf_engine: filter, sort and reassembly logic with its state registers.
// Depends on jcrf_pkg.
module jcrf_engine
   import jcrf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       fire,
   input  item_type   item,
   output result_type result
);

   logic [7:0]  stamp_count_ff, stamp_count_in;
   logic [15:0] pending_pgn_ff, pending_pgn_in;
   logic [7:0]  total_packets_ff, total_packets_in;
   logic [1:0]  buzzer_one_ff, buzzer_one_in;
   logic [1:0]  buzzer_two_ff, buzzer_two_in;
   logic [16:0] silence_ff, silence_in;

   logic [7:0]  pf, ps, sa, seq, stamp_inc, seq_m1;
   logic [16:0] silence_inc;
   logic        clear_silence, is_bcast, is_tp;
   result_type  r;

   assign pf  = item.ext_id[23:16];
   assign ps  = item.ext_id[15:8];
   assign sa  = item.ext_id[7:0];
   assign seq = item.data_low[7:0];
   assign seq_m1      = seq - 8'd1;
   assign stamp_inc   = stamp_count_ff + 8'd1;
   assign silence_inc = silence_ff + 17'd1;
   assign is_bcast = (pf == PF_BCAST) || (pf == PF_PROP_B) || (pf == PF_PROP_A);
   assign is_tp    = ((pf == PF_TP_DT) || (pf == PF_TP_CM)) &&
                     ((ps == PS_GLOBAL) || (ps == PS_TP_DEST));

   // Work out the result and the next state for the item in hand
   always_comb begin
      r                = '0;
      stamp_count_in   = stamp_count_ff;
      pending_pgn_in   = pending_pgn_ff;
      total_packets_in = total_packets_ff;
      buzzer_one_in    = buzzer_one_ff;
      buzzer_two_in    = buzzer_two_ff;
      silence_in       = silence_ff;
      clear_silence    = 1'b1;

      if (item.op == OP_TICK) begin
         // Count ticks, saturating one past the timeout
         silence_in = silence_inc;
         if (silence_inc >= {1'b0, cfg.comm_timeout})
            silence_in = {1'b0, cfg.comm_timeout} + 17'd1;
      end else if (source_listed(sa)) begin
         r.accepted = 1'b1;
         stamp_count_in = stamp_inc;
         if (stamp_inc >= cfg.stamp_interval) begin
            stamp_count_in = '0;
            r.stamp_due    = 1'b1;
         end
         if (is_bcast) begin
            if (ps == PS_MONITOR) begin
               r.monitor_reset = 1'b1;
            end else begin
               if (ps == PS_BUZZ_1) begin
                  buzzer_one_in   = item.data_high[29:28];
                  r.buzzer_update = 1'b1;
               end else if (ps == PS_BUZZ_2) begin
                  buzzer_two_in   = item.data_low[3:2];
                  r.buzzer_update = 1'b1;
               end
               r.forward    = 1'b1;
               r.mirror_sel = mirror_of(item.ext_id);
            end
         end else if (is_tp) begin
            if ((pf == PF_TP_CM) && (item.data_low[7:0] == TP_CTRL_BAM)) begin
               // Announcement: open a transfer
               pending_pgn_in = item.data_high[23:8];
               if (item.data_high[23:8] == cfg.target_pgn) begin
                  total_packets_in = item.data_low[31:24];
               end else begin
                  r.forward    = 1'b1;
                  r.mirror_sel = mirror_of(item.ext_id);
               end
               clear_silence = 1'b0;
            end else if ((pending_pgn_ff != '0) && (pf == PF_TP_DT)) begin
               if (pending_pgn_ff == cfg.target_pgn) begin
                  // Data packet of the local PGN: emit a segment write for a sequence within the buffer
                  if ((seq != '0) && (seq <= MAX_SEGMENTS)) begin
                     r.seg_write  = 1'b1;
                     r.seg_offset = seq_m1[6:0] * 7'd7;
                     r.seg_data   = {item.data_high, item.data_low[31:8]};
                  end
                  if (seq == total_packets_ff) begin
                     pending_pgn_in   = '0;
                     total_packets_in = '0;
                     r.message_done   = 1'b1;
                  end
               end else begin
                  r.forward    = 1'b1;
                  r.mirror_sel = mirror_of(item.ext_id);
               end
            end
         end
         if (clear_silence) silence_in = '0;
      end

      r.buzzer_active = (buzzer_one_in == 2'd1) || (buzzer_two_in == 2'd1);
      r.comm_lost     = silence_in >= {1'b0, cfg.comm_timeout};
   end

   // Commit the state when the item moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         stamp_count_ff   <= '0;
         pending_pgn_ff   <= '0;
         total_packets_ff <= '0;
         buzzer_one_ff    <= '0;
         buzzer_two_ff    <= '0;
         silence_ff       <= '0;
      end else if (fire) begin
         stamp_count_ff   <= stamp_count_in;
         pending_pgn_ff   <= pending_pgn_in;
         total_packets_ff <= total_packets_in;
         buzzer_one_ff    <= buzzer_one_in;
         buzzer_two_ff    <= buzzer_two_in;
         silence_ff       <= silence_in;
      end
   end

   assign result = r;

endmodule

// ===== sv/j1939_can_rx_filter_reassembler_top.sv =====
// Channel   | Handshake              | Payload
// req       | req_valid / req_ready  | req_op, req_ext_id, req_data_low, req_data_high
// rsp       | rsp_valid / rsp_ready  | rsp_accepted ... rsp_comm_lost, one per request
// csr       | csr_we (no wait)       | csr_index, csr_wdata
//
// One request per cycle sustained while rsp_ready holds; the input register takes a request
// at its transfer edge and passes it on to the result register once that register is free,
// and rsp_valid rises when the result register is loaded. Synchronous active-high reset clears
// the valid flags and filter state and loads the register defaults. A stalled rsp holds the result
// register; the input register keeps taking requests until it is also full. Depends on jcrf_pkg and its submodules.
module j1939_can_rx_filter_reassembler_top
   import jcrf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_op,
   input  logic [28:0]         req_ext_id,
   input  logic [31:0]         req_data_low,
   input  logic [31:0]         req_data_high,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_accepted,
   output logic                rsp_forward,
   output logic [2:0]          rsp_mirror_sel,
   output logic                rsp_stamp_due,
   output logic                rsp_monitor_reset,
   output logic                rsp_buzzer_update,
   output logic                rsp_buzzer_active,
   output logic                rsp_seg_write,
   output logic [6:0]          rsp_seg_offset,
   output logic [55:0]         rsp_seg_data,
   output logic                rsp_message_done,
   output logic                rsp_comm_lost
);

   cfg_type    cfg;
   item_type   req_item, stage_item;
   logic       stage_valid, fire, out_free;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type result, rsp_ff;

   assign req_item = '{op: req_op, ext_id: req_ext_id,
                       data_low: req_data_low, data_high: req_data_high};

   jcrf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   jcrf_in_stage u_in (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_item    (req_item),
      .stage_valid (stage_valid),
      .stage_take  (fire),
      .stage_item  (stage_item)
   );

   // Advance the held request when the result register is free
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign fire     = stage_valid && out_free;

   jcrf_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .fire   (fire),
      .item   (stage_item),
      .result (result)
   );

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) rsp_valid_in = stage_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) rsp_ff <= result;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = rsp_ff.accepted;
   assign rsp_forward       = rsp_ff.forward;
   assign rsp_mirror_sel    = rsp_ff.mirror_sel;
   assign rsp_stamp_due     = rsp_ff.stamp_due;
   assign rsp_monitor_reset = rsp_ff.monitor_reset;
   assign rsp_buzzer_update = rsp_ff.buzzer_update;
   assign rsp_buzzer_active = rsp_ff.buzzer_active;
   assign rsp_seg_write     = rsp_ff.seg_write;
   assign rsp_seg_offset    = rsp_ff.seg_offset;
   assign rsp_seg_data      = rsp_ff.seg_data;
   assign rsp_message_done  = rsp_ff.message_done;
   assign rsp_comm_lost     = rsp_ff.comm_lost;

endmodule

// ===== test/jcrf_checker.sv =====
// jcrf_checker: scoreboard for the J1939 receive filter and BAM reassembler.
// Follows register writes, predicts one result per request transfer and compares
// every result transfer with the oldest prediction. Depends on jcrf_pkg.
module jcrf_checker
   import jcrf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic                req_op,
   input  logic [28:0]         req_ext_id,
   input  logic [31:0]         req_data_low,
   input  logic [31:0]         req_data_high,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic                rsp_accepted,
   input  logic                rsp_forward,
   input  logic [2:0]          rsp_mirror_sel,
   input  logic                rsp_stamp_due,
   input  logic                rsp_monitor_reset,
   input  logic                rsp_buzzer_update,
   input  logic                rsp_buzzer_active,
   input  logic                rsp_seg_write,
   input  logic [6:0]          rsp_seg_offset,
   input  logic [55:0]         rsp_seg_data,
   input  logic                rsp_message_done,
   input  logic                rsp_comm_lost,
   output int                  mismatch_count,
   output int                  outstanding
);

   // Register copies
   logic [15:0] target_pgn;
   logic [7:0]  stamp_interval;
   logic [15:0] comm_timeout;

   // Filter state
   logic [7:0]  stamp_count;
   logic [15:0] pending_pgn;
   logic [7:0]  total_packets;
   logic [1:0]  buzzer_one;
   logic [1:0]  buzzer_two;
   logic [16:0] silence_ticks;

   result_type  frame_outcome_q[$];
   int          bad_fields;
   int          reports;

   function automatic logic sa_known(input logic [7:0] sa);
      case (sa)
         SA_0, SA_1, SA_2, SA_3, SA_4, SA_5, SA_6: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic mirror_type identifier_mirror(input logic [28:0] id);
      case (id)
         ID_RELAY: return MIRROR_RELAY;
         ID_HYD:   return MIRROR_HYD;
         ID_AUTO:  return MIRROR_AUTO;
         ID_LAMP:  return MIRROR_LAMP;
         default:  return MIRROR_NONE;
      endcase
   endfunction

   // Advance the filter state by one request and return the result it yields
   function automatic result_type filter_frame(input item_type it);
      result_type  r;
      logic [63:0] payload;
      logic [7:0]  pf;
      logic [7:0]  ps;
      logic [7:0]  seq;
      logic [7:0]  offset;
      logic        clear_silence;
      r = '0;
      payload = {it.data_high, it.data_low};
      pf = it.ext_id[23:16];
      ps = it.ext_id[15:8];
      clear_silence = 1'b1;
      if (it.op == OP_TICK) begin
         // saturate just above the timeout
         silence_ticks = silence_ticks + 17'd1;
         if (silence_ticks >= {1'b0, comm_timeout})
            silence_ticks = {1'b0, comm_timeout} + 17'd1;
      end else if (sa_known(it.ext_id[7:0])) begin
         r.accepted = 1'b1;
         stamp_count = stamp_count + 8'd1;
         if (stamp_count >= stamp_interval) begin
            stamp_count = 8'd0;
            r.stamp_due = 1'b1;
         end
         if (pf == PF_BCAST || pf == PF_PROP_B || pf == PF_PROP_A) begin
            if (ps == PS_MONITOR) begin
               r.monitor_reset = 1'b1;
            end else begin
               if (ps == PS_BUZZ_1) begin
                  buzzer_one = payload[61:60];
                  r.buzzer_update = 1'b1;
               end else if (ps == PS_BUZZ_2) begin
                  buzzer_two = payload[3:2];
                  r.buzzer_update = 1'b1;
               end
               r.forward = 1'b1;
               r.mirror_sel = identifier_mirror(it.ext_id);
            end
         end else if ((pf == PF_TP_DT || pf == PF_TP_CM) &&
                      (ps == PS_GLOBAL || ps == PS_TP_DEST)) begin
            if (pf == PF_TP_CM && payload[7:0] == TP_CTRL_BAM) begin
               // announcement: open a transfer, keep the silence count
               pending_pgn = payload[55:40];
               if (pending_pgn == target_pgn) begin
                  total_packets = payload[31:24];
               end else begin
                  r.forward = 1'b1;
                  r.mirror_sel = identifier_mirror(it.ext_id);
               end
               clear_silence = 1'b0;
            end else if (pending_pgn != 16'd0 && pf == PF_TP_DT) begin
               if (pending_pgn == target_pgn) begin
                  seq = payload[7:0];
                  if (seq >= 8'd1 && seq <= MAX_SEGMENTS) begin
                     offset = (seq - 8'd1) * 8'd7;
                     r.seg_write = 1'b1;
                     r.seg_offset = offset[6:0];
                     r.seg_data = payload[63:8];
                  end
                  if (seq == total_packets) begin
                     pending_pgn = 16'd0;
                     total_packets = 8'd0;
                     r.message_done = 1'b1;
                  end
               end else begin
                  r.forward = 1'b1;
                  r.mirror_sel = identifier_mirror(it.ext_id);
               end
            end
         end
         if (clear_silence) silence_ticks = 17'd0;
      end
      r.buzzer_active = (buzzer_one == 2'd1) || (buzzer_two == 2'd1);
      r.comm_lost = silence_ticks >= {1'b0, comm_timeout};
      return r;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         bad_fields++;
         if (reports < 100) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            reports++;
         end
      end
   endtask

   task automatic compare_outcome(input result_type want, input result_type got);
      bad_fields = 0;
      check_field("accepted", want.accepted, got.accepted);
      check_field("forward", want.forward, got.forward);
      check_field("mirror_sel", want.mirror_sel, got.mirror_sel);
      check_field("stamp_due", want.stamp_due, got.stamp_due);
      check_field("monitor_reset", want.monitor_reset, got.monitor_reset);
      check_field("buzzer_update", want.buzzer_update, got.buzzer_update);
      check_field("buzzer_active", want.buzzer_active, got.buzzer_active);
      check_field("seg_write", want.seg_write, got.seg_write);
      check_field("seg_offset", want.seg_offset, got.seg_offset);
      check_field("seg_data", want.seg_data, got.seg_data);
      check_field("message_done", want.message_done, got.message_done);
      check_field("comm_lost", want.comm_lost, got.comm_lost);
      if (bad_fields != 0) mismatch_count++;
   endtask

   // Compare result transfers first, then predict the request transfer of this edge
   always @(posedge clock) begin : watch
      result_type got;
      item_type   it;
      if (reset) begin
         target_pgn = TARGET_PGN_RST;
         stamp_interval = STAMP_INTERVAL_RST;
         comm_timeout = COMM_TIMEOUT_RST;
         stamp_count = 8'd0;
         pending_pgn = 16'd0;
         total_packets = 8'd0;
         buzzer_one = 2'd0;
         buzzer_two = 2'd0;
         silence_ticks = 17'd0;
         frame_outcome_q.delete();
         mismatch_count = 0;
         reports = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.accepted = rsp_accepted;
            got.forward = rsp_forward;
            got.mirror_sel = mirror_type'(rsp_mirror_sel);
            got.stamp_due = rsp_stamp_due;
            got.monitor_reset = rsp_monitor_reset;
            got.buzzer_update = rsp_buzzer_update;
            got.buzzer_active = rsp_buzzer_active;
            got.seg_write = rsp_seg_write;
            got.seg_offset = rsp_seg_offset;
            got.seg_data = rsp_seg_data;
            got.message_done = rsp_message_done;
            got.comm_lost = rsp_comm_lost;
            if (frame_outcome_q.size() == 0) begin
               mismatch_count++;
               if (reports < 100) begin
                  $display("%0t: result transfer, expected none, got %0h", $time, got);
                  reports++;
               end
            end else begin
               compare_outcome(frame_outcome_q.pop_front(), got);
            end
         end
         if (req_valid && req_ready) begin
            it = {req_op, req_ext_id, req_data_low, req_data_high};
            frame_outcome_q.push_back(filter_frame(it));
         end
         if (csr_we) begin
            case (csr_index)
               CSR_TARGET_PGN:     target_pgn = csr_wdata;
               CSR_STAMP_INTERVAL: stamp_interval = csr_wdata[7:0];
               CSR_COMM_TIMEOUT:   comm_timeout = csr_wdata;
               default: ;
            endcase
         end
      end
      outstanding = frame_outcome_q.size();
   end

endmodule

// ===== test/tb_j1939_can_rx_filter_reassembler_top.sv =====
// tb_j1939_can_rx_filter_reassembler_top: stimulus and verdict for the J1939 filter.
// Drives directed and random frames, ticks and register settings; jcrf_checker
// does the prediction. Depends on jcrf_pkg, jcrf_checker and the block.
module tb_j1939_can_rx_filter_reassembler_top;
   import jcrf_pkg::*;

   localparam int WatchdogLimit = 2000;
   localparam int PhaseCount = 6;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_we = 1'b0;
   logic [CsrIdxW-1:0]  csr_index = CSR_TARGET_PGN;
   logic [CsrDataW-1:0] csr_wdata = '0;
   logic                req_valid = 1'b0;
   logic                req_op = OP_FRAME;
   logic [28:0]         req_ext_id = '0;
   logic [31:0]         req_data_low = '0;
   logic [31:0]         req_data_high = '0;
   logic                rsp_ready = 1'b0;
   logic                req_ready;
   logic                rsp_valid;
   logic                rsp_accepted;
   logic                rsp_forward;
   logic [2:0]          rsp_mirror_sel;
   logic                rsp_stamp_due;
   logic                rsp_monitor_reset;
   logic                rsp_buzzer_update;
   logic                rsp_buzzer_active;
   logic                rsp_seg_write;
   logic [6:0]          rsp_seg_offset;
   logic [55:0]         rsp_seg_data;
   logic                rsp_message_done;
   logic                rsp_comm_lost;

   int          mismatch_count;
   int          outstanding;
   int          burst_left = 0;
   int          idle_cycles = 0;
   int          items_sent = 0;
   int          stall_step = 0;
   logic [15:0] stall_bits = '1;
   logic [15:0] pgn_now = TARGET_PGN_RST;

   always #1 clock = ~clock;

   j1939_can_rx_filter_reassembler_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_ext_id       (req_ext_id),
      .req_data_low     (req_data_low),
      .req_data_high    (req_data_high),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_accepted     (rsp_accepted),
      .rsp_forward      (rsp_forward),
      .rsp_mirror_sel   (rsp_mirror_sel),
      .rsp_stamp_due    (rsp_stamp_due),
      .rsp_monitor_reset(rsp_monitor_reset),
      .rsp_buzzer_update(rsp_buzzer_update),
      .rsp_buzzer_active(rsp_buzzer_active),
      .rsp_seg_write    (rsp_seg_write),
      .rsp_seg_offset   (rsp_seg_offset),
      .rsp_seg_data     (rsp_seg_data),
      .rsp_message_done (rsp_message_done),
      .rsp_comm_lost    (rsp_comm_lost)
   );

   jcrf_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_ext_id       (req_ext_id),
      .req_data_low     (req_data_low),
      .req_data_high    (req_data_high),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_accepted     (rsp_accepted),
      .rsp_forward      (rsp_forward),
      .rsp_mirror_sel   (rsp_mirror_sel),
      .rsp_stamp_due    (rsp_stamp_due),
      .rsp_monitor_reset(rsp_monitor_reset),
      .rsp_buzzer_update(rsp_buzzer_update),
      .rsp_buzzer_active(rsp_buzzer_active),
      .rsp_seg_write    (rsp_seg_write),
      .rsp_seg_offset   (rsp_seg_offset),
      .rsp_seg_data     (rsp_seg_data),
      .rsp_message_done (rsp_message_done),
      .rsp_comm_lost    (rsp_comm_lost),
      .mismatch_count   (mismatch_count),
      .outstanding      (outstanding)
   );

   // Result side: stall on a 16-bit pattern, reloaded each window, sometimes all ready
   always @(posedge clock) begin
      if (stall_step == 0) begin
         case ($urandom_range(0, 3))
            0:       stall_bits = '1;
            1:       stall_bits = $urandom;
            default: stall_bits = $urandom | $urandom;
         endcase
      end
      rsp_ready <= stall_bits[stall_step];
      stall_step = (stall_step + 1) % 16;
   end

   // Watchdog: end the run when no transfer happens for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [7:0] pick_listed();
      case ($urandom_range(0, 6))
         0:       return SA_0;
         1:       return SA_1;
         2:       return SA_2;
         3:       return SA_3;
         4:       return SA_4;
         5:       return SA_5;
         default: return SA_6;
      endcase
   endfunction

   function automatic logic [7:0] pick_tp_ps();
      return ($urandom_range(0, 1) == 0) ? PS_GLOBAL : PS_TP_DEST;
   endfunction

   function automatic item_type frame_id(input logic [28:0] id, input logic [63:0] payload);
      item_type it;
      it.op = OP_FRAME;
      it.ext_id = id;
      it.data_low = payload[31:0];
      it.data_high = payload[63:32];
      return it;
   endfunction

   function automatic item_type frame(input logic [7:0] pf, input logic [7:0] ps,
                                      input logic [7:0] sa, input logic [63:0] payload);
      logic [31:0] upper;
      upper = $urandom;
      return frame_id({upper[4:0], pf, ps, sa}, payload);
   endfunction

   function automatic item_type tick_item();
      item_type it;
      logic [63:0] noise;
      noise = rand64();
      it = frame_id(noise[28:0], rand64());
      it.op = OP_TICK;
      return it;
   endfunction

   function automatic logic [63:0] bam_payload(input logic [15:0] pgn, input logic [7:0] count);
      logic [63:0] noise;
      noise = rand64();
      return {noise[63:56], pgn, noise[39:32], count, noise[23:8], TP_CTRL_BAM};
   endfunction

   function automatic logic [63:0] data_payload(input logic [7:0] seq);
      logic [63:0] noise;
      noise = rand64();
      return {noise[63:8], seq};
   endfunction

   // Present one request, in bursts with random gaps; hold it until the transfer
   task automatic send_req(input item_type it, input bit counted);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 12);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      {req_op, req_ext_id, req_data_low, req_data_high} <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
      if (counted) items_sent++;
   endtask

   // Drop valid and wait until every predicted result has come back
   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_config(input logic [15:0] pgn, input logic [7:0] interval,
                              input logic [15:0] timeout);
      csr_we <= 1'b1;
      csr_index <= CSR_TARGET_PGN;
      csr_wdata <= pgn;
      @(posedge clock);
      csr_index <= CSR_STAMP_INTERVAL;
      csr_wdata <= {8'd0, interval};
      @(posedge clock);
      csr_index <= CSR_COMM_TIMEOUT;
      csr_wdata <= timeout;
      @(posedge clock);
      csr_we <= 1'b0;
      pgn_now = pgn;
   endtask

   // Announcement followed by its data packets, with ticks and corruption mixed in
   task automatic send_bam_run(input logic [15:0] pgn, input logic [7:0] count,
                               input bit broken);
      logic [7:0] seq;
      int         s;
      send_req(frame(PF_TP_CM, pick_tp_ps(), pick_listed(), bam_payload(pgn, count)), 1'b1);
      for (s = 1; s <= count; s++) begin
         seq = s;
         if (broken && $urandom_range(0, 3) == 0) seq = $urandom_range(0, 255);
         if ($urandom_range(0, 9) == 0) send_req(tick_item(), 1'b1);
         if (broken && $urandom_range(0, 7) == 0)
            send_req(frame(PF_TP_DT, pick_tp_ps(), $urandom_range(0, 255),
                           data_payload(seq)), 1'b1);
         else
            send_req(frame(PF_TP_DT, pick_tp_ps(), pick_listed(), data_payload(seq)), 1'b1);
      end
   endtask

   task automatic send_broadcast();
      logic [7:0] pf;
      logic [7:0] ps;
      case ($urandom_range(0, 2))
         0:       pf = PF_BCAST;
         1:       pf = PF_PROP_B;
         default: pf = PF_PROP_A;
      endcase
      case ($urandom_range(0, 4))
         0:       ps = PS_MONITOR;
         1:       ps = PS_BUZZ_1;
         2:       ps = PS_BUZZ_2;
         default: ps = $urandom_range(0, 255);
      endcase
      if ($urandom_range(0, 4) == 0) begin
         case ($urandom_range(0, 3))
            0:       send_req(frame_id(ID_RELAY, rand64()), 1'b1);
            1:       send_req(frame_id(ID_HYD, rand64()), 1'b1);
            2:       send_req(frame_id(ID_AUTO, rand64()), 1'b1);
            default: send_req(frame_id(ID_LAMP, rand64()), 1'b1);
         endcase
      end else begin
         send_req(frame(pf, ps, pick_listed(), rand64()), 1'b1);
      end
   endtask

   // One random phase: well-formed and broken transfers, plus broadcasts, ticks and noise
   task automatic run_random(input int phase_items);
      logic [15:0] pgn;
      logic [7:0]  count;
      logic [63:0] noise;
      items_sent = 0;
      while (items_sent < phase_items) begin
         case ($urandom_range(0, 19))
            0, 1, 2: repeat ($urandom_range(1, 24)) send_req(tick_item(), 1'b1);
            3, 4, 5, 6: send_broadcast();
            7, 8, 9, 10, 11, 12, 13, 14: begin
               pgn = ($urandom_range(0, 4) != 0) ? pgn_now : 16'($urandom);
               case ($urandom_range(0, 5))
                  0:       count = $urandom_range(12, 16);
                  1:       count = 8'd0;
                  default: count = $urandom_range(1, 11);
               endcase
               send_bam_run(pgn, count, $urandom_range(0, 3) == 0);
            end
            15, 16: begin
               send_req(frame(($urandom_range(0, 1) == 0) ? PF_TP_DT : PF_TP_CM,
                              ($urandom_range(0, 2) == 0) ? 8'($urandom) : pick_tp_ps(),
                              pick_listed(), rand64()), 1'b1);
            end
            17: send_req(frame($urandom_range(0, 255), $urandom_range(0, 255),
                               pick_listed(), rand64()), 1'b1);
            default: begin
               noise = rand64();
               send_req(frame_id(noise[28:0], rand64()), 1'b0);
            end
         endcase
      end
   endtask

   initial begin : stimulus
      int phase;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: default registers
      send_req(tick_item(), 1'b1);
      send_req(frame(PF_BCAST, PS_MONITOR, 8'h00, '1), 1'b1);
      send_req(frame_id('1, '1), 1'b1);
      send_req(frame(PF_BCAST, PS_MONITOR, SA_0, '0), 1'b1);
      send_req(frame(PF_PROP_B, PS_BUZZ_1, SA_1, 64'h1000_0000_0000_0000), 1'b1);
      send_req(frame(PF_PROP_A, PS_BUZZ_2, SA_2, 64'h0000_0000_0000_0004), 1'b1);
      send_req(frame_id(ID_RELAY, rand64()), 1'b1);
      send_req(frame_id(ID_HYD, rand64()), 1'b1);
      send_req(frame_id(ID_AUTO, rand64()), 1'b1);
      send_req(frame_id(ID_LAMP, rand64()), 1'b1);
      // target transfer longer than the buffer: sequence zero, first, last slot, beyond
      send_req(frame(PF_TP_CM, PS_TP_DEST, SA_3, bam_payload(TARGET_PGN_RST, 8'd12)), 1'b1);
      send_req(frame(PF_TP_DT, PS_TP_DEST, SA_4, data_payload(8'd0)), 1'b1);
      send_req(frame(PF_TP_DT, PS_GLOBAL, SA_5, {56'hff_ffff_ffff_ffff, 8'd1}), 1'b1);
      send_req(frame(PF_TP_DT, PS_GLOBAL, SA_6, data_payload(MAX_SEGMENTS)), 1'b1);
      send_req(frame(PF_TP_DT, PS_GLOBAL, SA_0, data_payload(8'd12)), 1'b1);
      // transfer of another group is forwarded
      send_req(frame(PF_TP_CM, PS_GLOBAL, SA_1, bam_payload(16'h1234, 8'd2)), 1'b1);
      send_req(frame(PF_TP_DT, PS_GLOBAL, SA_2, data_payload(8'd1)), 1'b1);
      // transport frames that do nothing
      send_req(frame(PF_TP_CM, PS_GLOBAL, SA_3, {56'd0, 8'd16}), 1'b1);
      send_req(frame(PF_TP_DT, 8'h10, SA_4, rand64()), 1'b1);
      send_req(frame(8'h00, 8'h00, SA_5, '1), 1'b1);
      send_req(tick_item(), 1'b1);
      drain();

      // Random phases, each under its own register setting
      for (phase = 0; phase < PhaseCount; phase++) begin
         case (phase)
            0: load_config(16'hffff, 8'd1, 16'd1);
            1: load_config(16'h0000, 8'd255, 16'hffff);
            2: load_config(TARGET_PGN_RST, $urandom_range(1, 12), $urandom_range(2, 30));
            default: load_config($urandom, $urandom_range(1, 12), $urandom_range(2, 30));
         endcase
         run_random((phase == 1) ? 35 : 70);
         drain();
      end

      repeat (8) @(posedge clock);
      if (mismatch_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule
